### src/som_pkg.sv
package som_pkg;

	// register widths and saturation limit
	localparam int RATE_W   = 16;
	localparam int RADIUS_W = 5;
	localparam int DIST_W   = 35;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// divider operand widths: the divisor is 1 + |dy| + |dx| with both at most 15
	localparam int DIV_W = 6;

	// item modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_POINT = 2'd2;

	// result kinds
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_TRAIN = 1'b1;

	// register indexes
	localparam logic REG_RATE   = 1'b0;
	localparam logic REG_RADIUS = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_SCAN,
		S_WIN,
		S_CELL,
		S_DIV,
		S_URD,
		S_UMUL,
		S_UWR,
		S_DONE
	} state_t;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [RATE_W-1:0] dividend;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [RATE_W-1:0] quotient;
	} div_rsp_t;

endpackage

### src/som_ram.sv
module som_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/som_div.sv
module som_div (
	input  logic              clk,
	input  logic              arst_n,
	input  som_pkg::div_req_t req,
	output som_pkg::div_rsp_t rsp
);

	localparam int N_W = som_pkg::RATE_W;
	localparam int D_W = som_pkg::DIV_W;
	localparam int C_W = $clog2(N_W);

	logic           busy_q;
	logic           done_q;
	logic [C_W-1:0] cnt_q;
	logic [N_W-1:0] num_q;
	logic [D_W-1:0] den_q;
	logic [D_W-1:0] rem_q;
	logic [D_W:0]   rem_sh;
	logic           fit;
	logic [D_W:0]   rem_sub;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q, num_q[N_W-1]};
		fit     = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// control: start, count steps, flag the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == C_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[N_W-2:0], fit};
			rem_q <= fit ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

### src/som_train_step_core.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | mode row col elem value last
// out     | output    | out_valid / out_stall | kind read_data win_row win_col win_distance
// cfg     | input     | APB psel/penable      | learn_rate (0x0), neighbour_radius (0x4)
//
// A weight write goes straight to the RAM; a read passes the RAM read register, then the result register.
// A training point's last element runs the scan, one element a cycle through the
// single weight RAM read port, then S_WIN sets up the window.
// Each window cell then runs the shared divider, then each element goes through read,
// multiply and write-back through the same RAM port.
// Input stalls while a step is running or a result waits; the weight RAM is not
// cleared by reset.
module som_train_step_core #(
	parameter int GRID_ROWS   = 16,
	parameter int GRID_COLS   = 16,
	parameter int VECTOR_DIM  = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             mode,
	input  logic [3:0]             row,
	input  logic [3:0]             col,
	input  logic [2:0]             elem,
	input  logic [SAMPLE_BITS-1:0] value,
	input  logic                   last,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   kind,
	output logic [SAMPLE_BITS-1:0] read_data,
	output logic [3:0]             win_row,
	output logic [3:0]             win_col,
	output logic [34:0]            win_distance,

	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int S      = SAMPLE_BITS;
	localparam int CELLS  = GRID_ROWS * GRID_COLS;
	localparam int DEPTH  = CELLS * VECTOR_DIM;
	localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int ROW_W  = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
	localparam int COL_W  = GRID_COLS > 1 ? $clog2(GRID_COLS) : 1;
	localparam int ELEM_W = VECTOR_DIM > 1 ? $clog2(VECTOR_DIM) : 1;
	localparam int MAXRC  = GRID_ROWS > GRID_COLS ? GRID_ROWS : GRID_COLS;
	localparam int WIN_W  = $clog2(MAXRC + 33) + 2;
	localparam int DW     = som_pkg::DIST_W;
	localparam int PROD_W = S + 18;

	som_pkg::state_t state_q, state_d;

	// configuration registers
	logic [som_pkg::RATE_W-1:0]   learn_rate_q;
	logic [som_pkg::RADIUS_W-1:0] radius_q;

	// input handshake and decode
	logic              accept;
	logic              addr_ok;
	logic [ADDR_W-1:0] in_addr;
	logic [ELEM_W-1:0] in_pidx;

	// weight RAM ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [S-1:0]      ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [S-1:0]      ram_rdata;

	logic [S-1:0] point_q [VECTOR_DIM];
	logic         rd_ok_q;

	// scan issue counters and pipeline
	logic              iss_on_q;
	logic [ADDR_W-1:0] iss_addr_q;
	logic [ROW_W-1:0]  iss_row_q;
	logic [COL_W-1:0]  iss_col_q;
	logic [ELEM_W-1:0] iss_elem_q;
	logic              iss_end;
	logic              v_s1;
	logic [ELEM_W-1:0] elem_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic              v_s2;
	logic              first_s2;
	logic              lastel_s2;
	logic              cell0_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [COL_W-1:0]  col_s2;
	logic [DW-1:0]     sq_s2;

	logic signed [S:0] diff_sc;
	logic [S:0]        abs_sc;
	logic [17:0]       a18;
	logic [35:0]       sq36;
	logic [DW-1:0]     sq_sat;
	logic [DW:0]       sum_wide;
	logic [DW-1:0]     tot;

	logic [DW-1:0]    sum_q;
	logic [DW-1:0]    best_q;
	logic [ROW_W-1:0] best_row_q;
	logic [COL_W-1:0] best_col_q;

	// window walk
	logic signed [WIN_W-1:0] wr, wc, rad;
	logic signed [WIN_W-1:0] y0_c, y1_c, x0_c, x1_c;
	logic signed [WIN_W-1:0] y_q, y1_q, x_q, x0_q, x1_q;
	logic signed [WIN_W-1:0] dy, dx;
	logic                    win_empty;
	logic [ADDR_W-1:0]       base_q;
	logic [ADDR_W-1:0]       cell_base;
	logic [ELEM_W-1:0]       j_q;
	logic                    j_end;
	logic                    cell_end;
	logic                    win_end;

	// update arithmetic
	som_pkg::div_req_t div_req;
	som_pkg::div_rsp_t div_rsp;
	logic [som_pkg::RATE_W-1:0] l2_q;
	logic [S-1:0]               w_q;
	logic signed [S:0]          diff_up;
	logic signed [16:0]         l2_sx;
	logic signed [PROD_W-1:0]   prod_c, prod_q;
	logic signed [S+1:0]        step_c;
	logic signed [S+1:0]        w_ext;
	logic [S-1:0]               w_new;

	// output register
	logic                   out_valid_q;
	logic                   kind_q;
	logic [S-1:0]           read_data_q;
	logic [3:0]             win_row_q;
	logic [3:0]             win_col_q;
	logic [DW-1:0]          win_distance_q;

	som_ram #(
		.WIDTH (S),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_weights (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	som_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// input decode
	assign in_stall = (state_q != som_pkg::S_IDLE) || out_valid_q;
	assign accept   = in_valid && !in_stall;
	assign addr_ok  = (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS)
		&& (32'(elem) < VECTOR_DIM);
	assign in_addr  = ADDR_W'((32'(row) * GRID_COLS + 32'(col)) * VECTOR_DIM + 32'(elem));
	assign in_pidx  = ELEM_W'(elem);

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == som_pkg::REG_RADIUS) ? 32'(radius_q) : 32'(learn_rate_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= som_pkg::RATE_W'(3277);
			radius_q     <= som_pkg::RADIUS_W'(2);
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == som_pkg::REG_RATE) begin
				learn_rate_q <= pwdata[som_pkg::RATE_W-1:0];
			end else begin
				radius_q <= pwdata[som_pkg::RADIUS_W-1:0];
			end
		end
	end

	// squared difference of one scanned element, saturated
	always_comb begin
		diff_sc  = $signed({point_q[elem_s1][S-1], point_q[elem_s1]})
			- $signed({ram_rdata[S-1], ram_rdata});
		abs_sc   = diff_sc[S] ? (S + 1)'(0) - diff_sc : diff_sc;
		a18      = 18'(abs_sc);
		sq36     = a18 * a18;
		sq_sat   = ((abs_sc >> 18) != '0 || sq36 > 36'(som_pkg::DIST_MAX))
			? som_pkg::DIST_MAX : DW'(sq36);
		sum_wide = {1'b0, sum_q} + {1'b0, sq_s2};
		if (first_s2) begin
			tot = sq_s2;
		end else if (sum_wide > {1'b0, som_pkg::DIST_MAX}) begin
			tot = som_pkg::DIST_MAX;
		end else begin
			tot = sum_wide[DW-1:0];
		end
	end

	assign iss_end = (iss_row_q == ROW_W'(GRID_ROWS - 1)) && (iss_col_q == COL_W'(GRID_COLS - 1))
		&& (iss_elem_q == ELEM_W'(VECTOR_DIM - 1));

	// window bounds around the winner, clipped to the grid
	always_comb begin
		wr   = WIN_W'($signed({1'b0, best_row_q}));
		wc   = WIN_W'($signed({1'b0, best_col_q}));
		rad  = WIN_W'($signed({1'b0, radius_q}));
		y0_c = (wr - rad < 0) ? '0 : wr - rad;
		x0_c = (wc - rad < 0) ? '0 : wc - rad;
		y1_c = (wr + rad > WIN_W'(GRID_ROWS)) ? WIN_W'(GRID_ROWS) : wr + rad;
		x1_c = (wc + rad > WIN_W'(GRID_COLS)) ? WIN_W'(GRID_COLS) : wc + rad;
		win_empty = (y0_c >= y1_c) || (x0_c >= x1_c);
		dy   = (wr > y_q) ? wr - y_q : y_q - wr;
		dx   = (wc > x_q) ? wc - x_q : x_q - wc;
		cell_base = ADDR_W'((int'(y_q) * GRID_COLS + int'(x_q)) * VECTOR_DIM);
		j_end    = j_q == ELEM_W'(VECTOR_DIM - 1);
		cell_end = (x_q + 1'b1) >= x1_q;
		win_end  = cell_end && ((y_q + 1'b1) >= y1_q);
	end

	// weight update arithmetic: multiply, then floor the step
	always_comb begin
		diff_up  = $signed({point_q[j_q][S-1], point_q[j_q]})
			- $signed({ram_rdata[S-1], ram_rdata});
		l2_sx    = $signed({1'b0, l2_q});
		prod_c   = l2_sx * diff_up;
		step_c   = (S + 2)'(prod_q >>> 16);
		w_ext    = (S + 2)'($signed(w_q));
		w_new    = S'(w_ext + step_c);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			som_pkg::S_IDLE: begin
				if (accept) begin
					case (mode)
						som_pkg::MODE_READ:  state_d = som_pkg::S_RD;
						som_pkg::MODE_POINT: state_d = last ? som_pkg::S_SCAN : som_pkg::S_IDLE;
						default:             state_d = som_pkg::S_IDLE;
					endcase
				end
			end
			som_pkg::S_RD:   state_d = som_pkg::S_IDLE;
			som_pkg::S_SCAN: begin
				if (!iss_on_q && !v_s1 && !v_s2) begin
					state_d = som_pkg::S_WIN;
				end
			end
			som_pkg::S_WIN:  state_d = win_empty ? som_pkg::S_DONE : som_pkg::S_CELL;
			som_pkg::S_CELL: state_d = som_pkg::S_DIV;
			som_pkg::S_DIV:  state_d = div_rsp.done ? som_pkg::S_URD : som_pkg::S_DIV;
			som_pkg::S_URD:  state_d = som_pkg::S_UMUL;
			som_pkg::S_UMUL: state_d = som_pkg::S_UWR;
			som_pkg::S_UWR: begin
				if (!j_end) begin
					state_d = som_pkg::S_URD;
				end else if (win_end) begin
					state_d = som_pkg::S_DONE;
				end else begin
					state_d = som_pkg::S_CELL;
				end
			end
			som_pkg::S_DONE: state_d = som_pkg::S_IDLE;
			default:         state_d = som_pkg::S_IDLE;
		endcase
	end

	// RAM and divider controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = in_addr;
		ram_wdata = value;
		ram_re    = 1'b0;
		ram_raddr = in_addr;
		div_req.start    = 1'b0;
		div_req.dividend = learn_rate_q;
		div_req.divisor  = som_pkg::DIV_W'(1 + dy + dx);
		case (state_q)
			som_pkg::S_IDLE: begin
				ram_we = accept && (mode == som_pkg::MODE_WRITE) && addr_ok;
				ram_re = accept && (mode == som_pkg::MODE_READ);
			end
			som_pkg::S_SCAN: begin
				ram_re    = iss_on_q;
				ram_raddr = iss_addr_q;
			end
			som_pkg::S_CELL: begin
				div_req.start = 1'b1;
			end
			som_pkg::S_URD: begin
				ram_re    = 1'b1;
				ram_raddr = base_q + ADDR_W'(j_q);
			end
			som_pkg::S_UWR: begin
				ram_we    = 1'b1;
				ram_waddr = base_q + ADDR_W'(j_q);
				ram_wdata = w_new;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= som_pkg::S_IDLE;
			iss_on_q    <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == som_pkg::S_SCAN) && iss_on_q;
			v_s2    <= v_s1;
			if (accept && mode == som_pkg::MODE_POINT && last) begin
				iss_on_q <= 1'b1;
			end else if (state_q == som_pkg::S_SCAN && iss_end) begin
				iss_on_q <= 1'b0;
			end
			if (state_q == som_pkg::S_RD || state_q == som_pkg::S_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// hold the point and the read address check
		if (accept) begin
			rd_ok_q <= addr_ok;
			if (mode == som_pkg::MODE_POINT && 32'(elem) < VECTOR_DIM) begin
				point_q[in_pidx] <= value;
			end
		end

		// advance the scan counters
		if (accept) begin
			iss_addr_q <= '0;
			iss_row_q  <= '0;
			iss_col_q  <= '0;
			iss_elem_q <= '0;
		end else if (state_q == som_pkg::S_SCAN && iss_on_q) begin
			iss_addr_q <= iss_addr_q + 1'b1;
			if (iss_elem_q == ELEM_W'(VECTOR_DIM - 1)) begin
				iss_elem_q <= '0;
				if (iss_col_q == COL_W'(GRID_COLS - 1)) begin
					iss_col_q <= '0;
					iss_row_q <= iss_row_q + 1'b1;
				end else begin
					iss_col_q <= iss_col_q + 1'b1;
				end
			end else begin
				iss_elem_q <= iss_elem_q + 1'b1;
			end
		end
		elem_s1 <= iss_elem_q;
		row_s1  <= iss_row_q;
		col_s1  <= iss_col_q;

		// square stage
		sq_s2     <= sq_sat;
		first_s2  <= elem_s1 == '0;
		lastel_s2 <= elem_s1 == ELEM_W'(VECTOR_DIM - 1);
		cell0_s2  <= (row_s1 == '0) && (col_s1 == '0);
		row_s2    <= row_s1;
		col_s2    <= col_s1;

		// accumulate and keep the first smallest cell
		if (v_s2) begin
			sum_q <= tot;
			if (lastel_s2 && (cell0_s2 || tot < best_q)) begin
				best_q     <= tot;
				best_row_q <= row_s2;
				best_col_q <= col_s2;
			end
		end

		// walk the window
		if (state_q == som_pkg::S_WIN) begin
			y_q  <= y0_c;
			y1_q <= y1_c;
			x_q  <= x0_c;
			x0_q <= x0_c;
			x1_q <= x1_c;
		end
		if (state_q == som_pkg::S_CELL) begin
			base_q <= cell_base;
		end
		if (state_q == som_pkg::S_DIV && div_rsp.done) begin
			l2_q <= div_rsp.quotient;
			j_q  <= '0;
		end
		if (state_q == som_pkg::S_UMUL) begin
			w_q    <= ram_rdata;
			prod_q <= prod_c;
		end
		if (state_q == som_pkg::S_UWR) begin
			j_q <= j_q + 1'b1;
			if (j_end) begin
				if (cell_end) begin
					x_q <= x0_q;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
		end

		// load the result register
		if (state_q == som_pkg::S_RD) begin
			kind_q         <= som_pkg::KIND_READ;
			read_data_q    <= rd_ok_q ? ram_rdata : '0;
			win_row_q      <= '0;
			win_col_q      <= '0;
			win_distance_q <= '0;
		end else if (state_q == som_pkg::S_DONE) begin
			kind_q         <= som_pkg::KIND_TRAIN;
			read_data_q    <= '0;
			win_row_q      <= 4'(best_row_q);
			win_col_q      <= 4'(best_col_q);
			win_distance_q <= best_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign read_data    = read_data_q;
	assign win_row      = win_row_q;
	assign win_col      = win_col_q;
	assign win_distance = win_distance_q;

	// the result register is free when a step finishes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == som_pkg::S_DONE || state_q == som_pkg::S_RD) |-> !out_valid_q)
		else $error("result register busy when a result is ready");

	// the divider runs only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == som_pkg::S_DIV))
		else $error("divider busy outside its wait state");

	// weights are written only by an accepted item or by the update step
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (accept || state_q == som_pkg::S_UWR))
		else $error("unexpected weight write");

	// the scan pipeline is empty before the window walk starts
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == som_pkg::S_WIN) |-> (!v_s1 && !v_s2 && !iss_on_q))
		else $error("scan pipeline not drained");

endmodule

### tb/tb_som_train_step_core.sv
module tb_som_train_step_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 16;
	localparam int COLS = 16;
	localparam int DIM = 8;
	localparam int CELLS = ROWS * COLS;
	localparam longint SAT_DIST = (64'd1 << 35) - 1;
	localparam int STALL_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 28;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  mode;
		logic [3:0]  row;
		logic [3:0]  col;
		logic [2:0]  elem;
		logic [15:0] value;
		logic        last;
	} som_item_t;

	typedef struct {
		logic        kind;
		logic [15:0] rdata;
		logic [3:0]  wrow;
		logic [3:0]  wcol;
		logic [34:0] wdist;
	} som_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic [3:0] row = '0;
	logic [3:0] col = '0;
	logic [2:0] elem = '0;
	logic [15:0] value = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic [15:0] read_data;
	logic [3:0] win_row;
	logic [3:0] win_col;
	logic [34:0] win_distance;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predictor state
	logic signed [15:0] weight_mem [CELLS*DIM];
	logic signed [15:0] point_mem [DIM];
	int rate_q = 3277;
	int radius_q = 2;

	som_item_t pending_items[$];
	som_result_t expected_results[$];
	som_item_t cur_item;
	int send_idle_pct = 12;
	int recv_idle_pct = 54;
	int mismatches = 0;
	int quiet_cycles = 0;

	som_train_step_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .row(row), .col(col), .elem(elem), .value(value), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .read_data(read_data), .win_row(win_row), .win_col(win_col),
		.win_distance(win_distance),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// find the best cell, then pull the window toward the point
	function automatic void train_step(output som_result_t res);
		longint best, dsum, d, l2, prod;
		int best_cell, wr, wc, y0, y1, x0, x1, dy, dx, base;
		best = 0;
		best_cell = 0;
		for (int c = 0; c < CELLS; c++) begin
			dsum = 0;
			for (int j = 0; j < DIM; j++) begin
				d = longint'(point_mem[j]) - longint'(weight_mem[c*DIM+j]);
				if (d < 0)
					d = -d;
				dsum += (d >= (64'd1 << 18)) ? SAT_DIST : d * d;
				if (dsum > SAT_DIST)
					dsum = SAT_DIST;
			end
			if (c == 0 || dsum < best) begin
				best = dsum;
				best_cell = c;
			end
		end
		wr = best_cell / COLS;
		wc = best_cell % COLS;
		y0 = (wr - radius_q < 0) ? 0 : wr - radius_q;
		x0 = (wc - radius_q < 0) ? 0 : wc - radius_q;
		y1 = (wr + radius_q > ROWS) ? ROWS : wr + radius_q;
		x1 = (wc + radius_q > COLS) ? COLS : wc + radius_q;
		for (int y = y0; y < y1; y++) begin
			for (int x = x0; x < x1; x++) begin
				dy = (wr > y) ? wr - y : y - wr;
				dx = (wc > x) ? wc - x : x - wc;
				l2 = rate_q / (1 + dy + dx);
				base = (y * COLS + x) * DIM;
				for (int j = 0; j < DIM; j++) begin
					prod = l2 * (longint'(point_mem[j]) - longint'(weight_mem[base+j]));
					weight_mem[base+j] = 16'(longint'(weight_mem[base+j]) + (prod >>> 16));
				end
			end
		end
		res.kind = som_pkg::KIND_TRAIN;
		res.rdata = '0;
		res.wrow = 4'(wr);
		res.wcol = 4'(wc);
		res.wdist = 35'(best);
	endfunction

	// apply one item to the predictor; returns 1 when it yields a result
	function automatic bit predict_item(input som_item_t it, output som_result_t res);
		int idx;
		idx = (int'(it.row) * COLS + int'(it.col)) * DIM + int'(it.elem);
		res.kind = som_pkg::KIND_READ;
		res.rdata = '0;
		res.wrow = '0;
		res.wcol = '0;
		res.wdist = '0;
		case (it.mode)
			som_pkg::MODE_WRITE: begin
				weight_mem[idx] = it.value;
			end
			som_pkg::MODE_READ: begin
				res.rdata = weight_mem[idx];
				return 1'b1;
			end
			som_pkg::MODE_POINT: begin
				point_mem[it.elem] = it.value;
				if (it.last) begin
					train_step(res);
					return 1'b1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// drive items from the pending queue, predicting each one as it is accepted
	always @(posedge clk) begin
		som_result_t res;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (predict_item(cur_item, res))
					expected_results.push_back(res);
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = pending_items.pop_front();
					in_valid <= 1'b1;
					mode <= cur_item.mode;
					row <= cur_item.row;
					col <= cur_item.col;
					elem <= cur_item.elem;
					value <= cur_item.value;
					last <= cur_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// check results, stall at random, watch for a hang
	always @(posedge clk) begin
		som_result_t exp_res;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind=%0d data=%h win=%0d,%0d dist=%0d",
							kind, read_data, win_row, win_col, win_distance);
				end else begin
					exp_res = expected_results.pop_front();
					if (kind !== exp_res.kind || read_data !== exp_res.rdata ||
					    win_row !== exp_res.wrow || win_col !== exp_res.wcol ||
					    win_distance !== exp_res.wdist) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected kind=%0d data=%h win=%0d,%0d dist=%0d",
								exp_res.kind, exp_res.rdata, exp_res.wrow, exp_res.wcol,
								exp_res.wdist);
							$display("          got kind=%0d data=%h win=%0d,%0d dist=%0d",
								kind, read_data, win_row, win_col, win_distance);
						end
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic som_item_t make_item(logic [1:0] m, int r, int c, int e, int v,
		logic l);
		som_item_t it;
		it.mode = m;
		it.row = 4'(r);
		it.col = 4'(c);
		it.elem = 3'(e);
		it.value = 16'(v);
		it.last = l;
		return it;
	endfunction

	function automatic som_item_t random_item();
		som_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.mode = (pick < 35) ? som_pkg::MODE_WRITE : (pick < 65) ? som_pkg::MODE_READ :
			(pick < 95) ? som_pkg::MODE_POINT : MODE_UNUSED;
		it.row = 4'($urandom_range(15));
		it.col = 4'($urandom_range(15));
		it.elem = 3'($urandom_range(7));
		it.value = 16'($urandom);
		it.last = (it.mode == som_pkg::MODE_POINT) ? ($urandom_range(3) == 0) : 1'($urandom);
		return it;
	endfunction

	// wait until the block has nothing left in flight
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic apb_write(logic idx, int data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(data);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == som_pkg::REG_RATE)
			rate_q = data & 16'hFFFF;
		else
			radius_q = data & 5'h1F;
	endtask

	initial begin
		int rates[5];
		int radii[5];
		rates = '{65535, 0, 1, 40000, 3277};
		radii = '{16, 0, 1, 3, 2};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// load every weight so nothing unwritten is ever read
		for (int c = 0; c < CELLS; c++)
			for (int j = 0; j < DIM; j++)
				pending_items.push_back(make_item(som_pkg::MODE_WRITE, c / COLS, c % COLS, j,
					(c == 0) ? 32767 : (c == CELLS - 1) ? -32768 : int'($urandom),
					1'b0));

		// extreme point, trains at default settings
		for (int j = 0; j < DIM; j++)
			pending_items.push_back(make_item(som_pkg::MODE_POINT, 0, 0, j,
				(j % 2) ? -32768 : 32767, j == DIM - 1));
		pending_items.push_back(make_item(som_pkg::MODE_READ, 0, 0, 0, 0, 1'b0));
		pending_items.push_back(make_item(som_pkg::MODE_READ, 15, 15, 7, 0, 1'b1));
		// unused mode and last on a write are both ignored
		pending_items.push_back(make_item(MODE_UNUSED, 3, 4, 5, 1234, 1'b1));
		pending_items.push_back(make_item(som_pkg::MODE_WRITE, 7, 8, 2, -1, 1'b1));
		pending_items.push_back(make_item(som_pkg::MODE_READ, 7, 8, 2, 0, 1'b0));
		wait_drained();

		// duplicate cell 1 into cell 3, then train on it: tie, earlier cell wins
		for (int j = 0; j < DIM; j++)
			pending_items.push_back(make_item(som_pkg::MODE_WRITE, 0, 3, j,
				int'(weight_mem[DIM+j]), 1'b0));
		for (int j = 0; j < DIM; j++)
			pending_items.push_back(make_item(som_pkg::MODE_POINT, 0, 0, j,
				int'(weight_mem[DIM+j]), j == DIM - 1));
		wait_drained();

		// random phases across register settings and idling patterns
		for (int p = 0; p < 5; p++) begin
			apb_write(som_pkg::REG_RATE, (p == 3) ? int'($urandom_range(65535)) : rates[p]);
			apb_write(som_pkg::REG_RADIUS, (p == 3) ? int'($urandom_range(4)) : radii[p]);
			send_idle_pct = (p < 2) ? 12 : (p < 4) ? 54 : 0;
			recv_idle_pct = (p < 2) ? 54 : (p < 4) ? 12 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				pending_items.push_back(random_item());
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
